### rtl/dhhp_pkg.sv
// Shared types and constants for the diff hunk header parser.
package dhhp_pkg;

  // Default width of a parsed line number.
  localparam int unsigned LINE_BITS_DEF = 24;

  // Fixed result field widths.
  localparam int unsigned CMD_W       = 8;
  localparam int unsigned LINE_W      = 24;
  localparam int unsigned COUNT_W     = 25;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = CMD_W + 4 * LINE_W + 2 * COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Characters of interest.
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LOW_D  = 8'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;  // 'z'
  localparam logic [CMD_W-1:0]  CMD_NONE    = 8'h00;

  // Position within the header line.
  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_OLD_START = 3'd1,
    PH_OLD_END   = 3'd2,
    PH_NEW_START = 3'd3,
    PH_NEW_END   = 3'd4,
    PH_DONE      = 3'd5,
    PH_DEAD      = 3'd6
  } phase_e;

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_letter(logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
           ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z));
  endfunction

endpackage

### rtl/dhhp_parse.sv
// Byte-serial header parser: phase, decimal accumulators and line snapshot.
module dhhp_parse #(
  parameter int unsigned LINE_BITS = dhhp_pkg::LINE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_valid_i,
  output logic                         byte_ready_o,
  input  logic [dhhp_pkg::CHAR_W-1:0]  char_i,
  input  logic                         last_i,
  output logic                         snap_valid_o,
  input  logic                         snap_ready_i,
  output logic [dhhp_pkg::CMD_W-1:0]   snap_letter_o,
  output logic [LINE_BITS-1:0]         snap_os_o,
  output logic [LINE_BITS-1:0]         snap_oe_o,
  output logic [LINE_BITS-1:0]         snap_ns_o,
  output logic [LINE_BITS-1:0]         snap_ne_o
);
  import dhhp_pkg::*;

  localparam int unsigned PW = LINE_BITS + 4;
  localparam logic [PW-1:0] VAL_MAX = {4'b0, {LINE_BITS{1'b1}}};

  phase_e               phase_q, phase_d, phase_n;
  logic [LINE_BITS-1:0] os_q, oe_q, ns_q, ne_q;
  logic [LINE_BITS-1:0] os_d, oe_d, ns_d, ne_d;
  logic [LINE_BITS-1:0] os_n, oe_n, ns_n, ne_n;
  logic [CMD_W-1:0]     letter_q, letter_d, letter_n;
  logic                 ocomma_q, ocomma_d, ocomma_n;
  logic                 ncomma_q, ncomma_d, ncomma_n;
  logic                 snap_valid_q, snap_valid_d;
  logic [CMD_W-1:0]     snap_letter_q, snap_letter_d;
  logic [LINE_BITS-1:0] snap_os_q, snap_oe_q, snap_ns_q, snap_ne_q;
  logic [LINE_BITS-1:0] snap_os_d, snap_oe_d, snap_ns_d, snap_ne_d;
  logic                 accept, dig, let_c, comma;
  logic [LINE_BITS-1:0] acc_sel, acc_new;
  logic [PW-1:0]        prod;

  assign byte_ready_o = !snap_valid_q || snap_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign dig          = is_digit(char_i);
  assign let_c        = is_letter(char_i);
  assign comma        = (char_i == CHAR_COMMA);

  // One shared acc*10+digit with saturation; the phase picks the accumulator.
  always_comb begin
    case (phase_q)
      PH_OLD_END:   acc_sel = oe_q;
      PH_NEW_START: acc_sel = ns_q;
      PH_NEW_END:   acc_sel = ne_q;
      default:      acc_sel = os_q;
    endcase
  end

  assign prod    = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                 + {{(PW - 4){1'b0}}, char_i[3:0]};
  assign acc_new = (prod > VAL_MAX) ? {LINE_BITS{1'b1}} : prod[LINE_BITS-1:0];

  // Next phase.
  always_comb begin
    phase_n = phase_q;
    unique case (phase_q)
      PH_FIRST:     phase_n = dig ? PH_OLD_START : PH_DEAD;
      PH_OLD_START: begin
        if (dig)        phase_n = PH_OLD_START;
        else if (comma) phase_n = PH_OLD_END;
        else if (let_c) phase_n = PH_NEW_START;
        else            phase_n = PH_DEAD;
      end
      PH_OLD_END: begin
        if (dig)        phase_n = PH_OLD_END;
        else if (let_c) phase_n = PH_NEW_START;
        else            phase_n = PH_DEAD;
      end
      PH_NEW_START: begin
        if (dig)        phase_n = PH_NEW_START;
        else if (comma) phase_n = PH_NEW_END;
        else            phase_n = PH_DONE;
      end
      PH_NEW_END:   phase_n = dig ? PH_NEW_END : PH_DONE;
      default:      phase_n = phase_q;
    endcase
  end

  // Datapath update for the current byte.
  always_comb begin
    os_n     = os_q;
    oe_n     = oe_q;
    ns_n     = ns_q;
    ne_n     = ne_q;
    letter_n = letter_q;
    ocomma_n = ocomma_q;
    ncomma_n = ncomma_q;
    unique case (phase_q)
      PH_FIRST: begin
        if (dig) os_n = acc_new;
      end
      PH_OLD_START: begin
        if (dig)        os_n = acc_new;
        else if (comma) ocomma_n = 1'b1;
        else if (let_c) letter_n = char_i;
      end
      PH_OLD_END: begin
        if (dig)        oe_n = acc_new;
        else if (let_c) letter_n = char_i;
      end
      PH_NEW_START: begin
        if (dig)        ns_n = acc_new;
        else if (comma) ncomma_n = 1'b1;
      end
      PH_NEW_END: begin
        if (dig) ne_n = acc_new;
      end
      default: ;
    endcase
  end

  // Commit: a last byte snapshots the line and restarts the parser.
  always_comb begin
    phase_d       = phase_q;
    os_d          = os_q;
    oe_d          = oe_q;
    ns_d          = ns_q;
    ne_d          = ne_q;
    letter_d      = letter_q;
    ocomma_d      = ocomma_q;
    ncomma_d      = ncomma_q;
    snap_valid_d  = snap_valid_q && !snap_ready_i;
    snap_letter_d = snap_letter_q;
    snap_os_d     = snap_os_q;
    snap_oe_d     = snap_oe_q;
    snap_ns_d     = snap_ns_q;
    snap_ne_d     = snap_ne_q;
    if (accept) begin
      if (last_i) begin
        phase_d       = PH_FIRST;
        os_d          = '0;
        oe_d          = '0;
        ns_d          = '0;
        ne_d          = '0;
        letter_d      = '0;
        ocomma_d      = 1'b0;
        ncomma_d      = 1'b0;
        snap_valid_d  = 1'b1;
        snap_letter_d = letter_n;
        snap_os_d     = os_n;
        snap_oe_d     = ocomma_n ? oe_n : os_n;
        snap_ns_d     = ns_n;
        snap_ne_d     = ncomma_n ? ne_n : ns_n;
      end else begin
        phase_d  = phase_n;
        os_d     = os_n;
        oe_d     = oe_n;
        ns_d     = ns_n;
        ne_d     = ne_n;
        letter_d = letter_n;
        ocomma_d = ocomma_n;
        ncomma_d = ncomma_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FIRST;
      os_q         <= '0;
      oe_q         <= '0;
      ns_q         <= '0;
      ne_q         <= '0;
      letter_q     <= '0;
      ocomma_q     <= 1'b0;
      ncomma_q     <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      os_q         <= os_d;
      oe_q         <= oe_d;
      ns_q         <= ns_d;
      ne_q         <= ne_d;
      letter_q     <= letter_d;
      ocomma_q     <= ocomma_d;
      ncomma_q     <= ncomma_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_letter_q <= snap_letter_d;
    snap_os_q     <= snap_os_d;
    snap_oe_q     <= snap_oe_d;
    snap_ns_q     <= snap_ns_d;
    snap_ne_q     <= snap_ne_d;
  end

  assign snap_valid_o  = snap_valid_q;
  assign snap_letter_o = snap_letter_q;
  assign snap_os_o     = snap_os_q;
  assign snap_oe_o     = snap_oe_q;
  assign snap_ns_o     = snap_ns_q;
  assign snap_ne_o     = snap_ne_q;

endmodule

### rtl/diff_hunk_header_parser_unit.sv
// Top level of the normal-format diff hunk header parser.
//
// Input stream: one ASCII byte of a header line per item (e.g. "4,5c4"),
// tlast on the final byte. An empty line is sent as a single newline byte.
// Output stream: one result item per line, carrying the command letter
// (0 when the line is not a command or a range runs backwards), both
// ranges with a missing end copied from its start, and the two line
// counts (old count 0 for 'a', new count 0 for 'd'). Values saturate at
// 2^LINE_BITS - 1. Without a command letter every field is 0.
// Throughput: one byte per cycle while tready is high; each digit byte is
// folded into the parser's shared multiply-by-ten accumulator.
// The edge that takes the last byte loads the line snapshot register; the
// output register is loaded from it through the count/compare stage once
// the output is free.
// Reset: the parser returns to the start of a line, all accumulators
// clear, and no result is pending.
// Stall: a held result keeps the output register; the snapshot register
// holds one more line, and tready drops while the snapshot is full and
// the output is held.
module diff_hunk_header_parser_unit #(
  parameter int unsigned LINE_BITS = dhhp_pkg::LINE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dhhp_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] char_in
  input  logic                            s_axis_tlast,   // line_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] command, [31:8] old_start, [55:32] old_end, [80:56] old_count,
  // [104:81] new_start, [128:105] new_end, [153:129] new_count, rest zero
  output logic [dhhp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dhhp_pkg::*;

  logic                 snap_valid, snap_ready, out_free, snap_fire;
  logic [CMD_W-1:0]     snap_letter;
  logic [LINE_BITS-1:0] snap_os, snap_oe, snap_ns, snap_ne;

  dhhp_parse #(
    .LINE_BITS(LINE_BITS)
  ) u_parse (
    .clk_i,
    .rst_ni,
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .char_i       (s_axis_tdata[CHAR_W-1:0]),
    .last_i       (s_axis_tlast),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_letter_o(snap_letter),
    .snap_os_o    (snap_os),
    .snap_oe_o    (snap_oe),
    .snap_ns_o    (snap_ns),
    .snap_ne_o    (snap_ne)
  );

  // Result stage: range checks, counts, command.
  logic                          old_back, new_back, no_letter;
  logic [LINE_BITS:0]            old_diff, new_diff;
  logic [LINE_BITS+COUNT_W:0]    old_cnt_ext, new_cnt_ext;
  logic [LINE_BITS+LINE_W-1:0]   os_ext, oe_ext, ns_ext, ne_ext;
  logic [COUNT_W-1:0]            old_cnt, new_cnt;
  logic [CMD_W-1:0]              cmd;
  logic [OUT_FIELD_W-1:0]        fields;
  logic [OUT_TDATA_W-1:0]        tdata_d, tdata_q;
  logic                          m_valid_q, m_valid_d;

  assign old_back  = snap_os > snap_oe;
  assign new_back  = snap_ns > snap_ne;
  assign no_letter = (snap_letter == CMD_NONE);
  assign old_diff  = {1'b0, snap_oe} - {1'b0, snap_os} + {{LINE_BITS{1'b0}}, 1'b1};
  assign new_diff  = {1'b0, snap_ne} - {1'b0, snap_ns} + {{LINE_BITS{1'b0}}, 1'b1};

  // Counts are kept to the result field width (mod 2^COUNT_W).
  assign old_cnt_ext = {{COUNT_W{1'b0}}, old_diff};
  assign new_cnt_ext = {{COUNT_W{1'b0}}, new_diff};
  assign os_ext      = {{LINE_W{1'b0}}, snap_os};
  assign oe_ext      = {{LINE_W{1'b0}}, snap_oe};
  assign ns_ext      = {{LINE_W{1'b0}}, snap_ns};
  assign ne_ext      = {{LINE_W{1'b0}}, snap_ne};

  always_comb begin
    old_cnt = old_back ? '0 : old_cnt_ext[COUNT_W-1:0];
    new_cnt = new_back ? '0 : new_cnt_ext[COUNT_W-1:0];
    if (snap_letter == CHAR_LOW_A) old_cnt = '0;
    else if (snap_letter == CHAR_LOW_D) new_cnt = '0;
    cmd = (old_back || new_back) ? CMD_NONE : snap_letter;
    fields = {new_cnt, ne_ext[LINE_W-1:0], ns_ext[LINE_W-1:0], old_cnt,
              oe_ext[LINE_W-1:0], os_ext[LINE_W-1:0], cmd};
    if (no_letter) fields = '0;
  end

  assign out_free   = !m_valid_q || m_axis_tready;
  assign snap_ready = out_free;
  assign snap_fire  = snap_valid && snap_ready;
  assign tdata_d    = snap_fire ? {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, fields} : tdata_q;
  assign m_valid_d  = snap_fire || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = tdata_q;

`ifndef ASSERT_OFF
  // Input stalls only when both the snapshot and the output are full and held.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (snap_valid && m_valid_q && !m_axis_tready))
    else $error("input stalled with room downstream");

  // A snapshot handed over must show up as a valid result.
  a_snap_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_fire |=> m_axis_tvalid)
    else $error("snapshot lost on the way to the output");

  // An add command never reports old lines.
  a_add_no_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[CMD_W-1:0] == CHAR_LOW_A))
      |-> (m_axis_tdata[CMD_W+2*LINE_W+COUNT_W-1:CMD_W+2*LINE_W] == '0))
    else $error("add command with nonzero old count");
`endif

endmodule
